/* src/core_count_load_governor_core_assert.svh */
// ----------------------------------------------------------------------------
// Core count load governor: assertion macros
// Implication checks in the single-clock, synchronous-reset style of the core.
// ----------------------------------------------------------------------------
`ifndef CORE_COUNT_LOAD_GOVERNOR_CORE_ASSERT_SVH
`define CORE_COUNT_LOAD_GOVERNOR_CORE_ASSERT_SVH

// same-cycle implication
`define CCLG_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("core count load governor: same-cycle check failed");

// next-cycle implication
`define CCLG_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("core count load governor: next-cycle check failed");

`endif

/* src/ccl_gov_pkg.sv */
// ----------------------------------------------------------------------------
// Core count load governor: package
// Shared constants, codes and control types.
// ----------------------------------------------------------------------------
`default_nettype none

package ccl_gov_pkg;

  localparam int MAX_CORES = 64;
  localparam int IDX_W     = (MAX_CORES > 1) ? $clog2(MAX_CORES) : 1;
  localparam int CORE_W    = ($clog2(MAX_CORES + 1) > 7) ? $clog2(MAX_CORES + 1) : 7;

  localparam int FIELD_W = 64;
  localparam int DIG_W   = 4;
  localparam int DIGITS  = FIELD_W / DIG_W;
  localparam int DCNT_W  = $clog2(DIGITS);

  localparam int Q_W      = 24;
  localparam int QF_W     = 16;
  localparam int QI_W     = Q_W - QF_W;
  localparam int MU_W     = 17;
  localparam int CFG_W    = 24;
  localparam int CFG_IDX_W = 3;

  localparam logic KIND_EST   = 1'b0;
  localparam logic KIND_CLEAR = 1'b1;

  localparam logic STRAT_LOAD = 1'b0;
  localparam logic STRAT_UTIL = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STRATEGY  = 3'd0,
    REG_LF_LIMIT  = 3'd1,
    REG_MAX_UTIL  = 3'd2,
    REG_IDLE_HYST = 3'd3,
    REG_ZC_FLOOR  = 3'd4
  } reg_idx_t;

  typedef enum logic [1:0] {
    DEC_HOLD = 2'd0,
    DEC_INC  = 2'd1,
    DEC_DEC  = 2'd2
  } dec_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_DIVGO,
    ST_DIVW,
    ST_DECIDE,
    ST_EMIT
  } gov_state_t;

  typedef struct packed {
    logic load;
    logic step;
  } dlt_ctrl_t;

endpackage

`default_nettype wire

/* src/core_count_load_governor_core.sv */
// ----------------------------------------------------------------------------
// Core count load governor: top level
// Takes cumulative counter snapshots and recommends hold, more or fewer
// cores.
//
// Input channel (in_valid/in_stall) carries one snapshot or clear-history
// beat; output channel (out_valid/out_stall) returns exactly one result
// beat per input beat. Configuration is a plain write port (cfg_wr_en,
// cfg_index, cfg_data), to be used while the block is idle.
// An estimate with history forms the deltas four bits at a time, starts the
// two parallel dividers (overflow check, 24 quotient bits, done check), then
// takes one decision step and an output load; the wait on the dividers ends
// early when both quotients saturate at the check. A recording-only snapshot
// forms the deltas before its output load; a clear-history beat goes straight
// to its output load. One item is in work at a time: in_stall is low only
// while the sequencer is idle, so no new beat is taken until the last result is loaded.
// A stalled result holds in the output register; the sequencer waits in
// its final state until that register is free.
// Reset restores the register defaults, drops history and marks every
// ramp threshold as zero; there is no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module core_count_load_governor_core (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_wr_en,
  input  logic [ccl_gov_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ccl_gov_pkg::CFG_W-1:0]        cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 kind,
  input  logic [6:0]                           active_cores,
  input  logic [ccl_gov_pkg::FIELD_W-1:0]      idle_cycle_count,
  input  logic [ccl_gov_pkg::FIELD_W-1:0]      total_cycle_count,
  input  logic [ccl_gov_pkg::FIELD_W-1:0]      weighted_load_count,
  input  logic [ccl_gov_pkg::FIELD_W-1:0]      sample_time,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [1:0]                           decision,
  output logic [ccl_gov_pkg::Q_W-1:0]          utilized_cores,
  output logic [ccl_gov_pkg::Q_W-1:0]          load_ratio,
  output logic                                 first_sample
);

  `include "core_count_load_governor_core_assert.svh"

  localparam int QW   = ccl_gov_pkg::Q_W;
  localparam int CW   = ccl_gov_pkg::CORE_W;
  localparam int IW   = ccl_gov_pkg::IDX_W;
  localparam int MUW  = ccl_gov_pkg::MU_W;
  localparam int HP_W = QW + CW;
  localparam int MP_W = MUW + CW;
  localparam int SW   = HP_W + 2;
  localparam int DCW  = ccl_gov_pkg::DCNT_W;

  // configuration
  logic           strategy;
  logic [QW-1:0]  load_factor_limit;
  logic [MUW-1:0] max_utilization;
  logic [QW-1:0]  idle_hysteresis;
  logic [QW-1:0]  zero_core_floor;

  always_ff @(posedge clk) begin
    if (rst) begin
      strategy          <= ccl_gov_pkg::STRAT_LOAD;
      load_factor_limit <= QW'(98304);
      max_utilization   <= MUW'(52429);
      idle_hysteresis   <= QW'(13107);
      zero_core_floor   <= QW'(32768);
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        ccl_gov_pkg::REG_STRATEGY:  strategy          <= cfg_data[0];
        ccl_gov_pkg::REG_LF_LIMIT:  load_factor_limit <= cfg_data[QW-1:0];
        ccl_gov_pkg::REG_MAX_UTIL:  max_utilization   <= cfg_data[MUW-1:0];
        ccl_gov_pkg::REG_IDLE_HYST: idle_hysteresis   <= cfg_data[QW-1:0];
        ccl_gov_pkg::REG_ZC_FLOOR:  zero_core_floor   <= cfg_data[QW-1:0];
        default: ;
      endcase
    end
  end

  // sequencer
  ccl_gov_pkg::gov_state_t state, state_next;
  ccl_gov_pkg::dlt_ctrl_t  dctl;
  logic                    div_start, emit, acc;
  logic [DCW-1:0]          dcnt;
  logic                    hist, rec;
  logic                    busy_u, busy_l;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ccl_gov_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    dctl       = '0;
    div_start  = 1'b0;
    emit       = 1'b0;
    unique case (state)
      ccl_gov_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if (kind == ccl_gov_pkg::KIND_CLEAR) begin
            state_next = ccl_gov_pkg::ST_EMIT;
          end else begin
            dctl.load  = 1'b1;
            state_next = ccl_gov_pkg::ST_SHIFT;
          end
        end
      end
      ccl_gov_pkg::ST_SHIFT: begin
        dctl.step = 1'b1;
        if (dcnt == DCW'(ccl_gov_pkg::DIGITS - 1)) begin
          state_next = rec ? ccl_gov_pkg::ST_EMIT : ccl_gov_pkg::ST_DIVGO;
        end
      end
      ccl_gov_pkg::ST_DIVGO: begin
        div_start  = 1'b1;
        state_next = ccl_gov_pkg::ST_DIVW;
      end
      ccl_gov_pkg::ST_DIVW: begin
        if (!busy_u && !busy_l) begin
          state_next = ccl_gov_pkg::ST_DECIDE;
        end
      end
      ccl_gov_pkg::ST_DECIDE: begin
        state_next = ccl_gov_pkg::ST_EMIT;
      end
      ccl_gov_pkg::ST_EMIT: begin
        if (!out_valid || !out_stall) begin
          emit       = 1'b1;
          state_next = ccl_gov_pkg::ST_IDLE;
        end
      end
      default: state_next = ccl_gov_pkg::ST_IDLE;
    endcase
  end

  assign acc = in_valid && !in_stall;

  // deltas and division
  logic [ccl_gov_pkg::FIELD_W-1:0] d_busy, d_total, d_weighted, d_time;
  logic                            time_nz;
  logic [QW-1:0]                   util_q, lf_q;

  ccl_gov_delta u_delta (
    .clk         (clk),
    .ctrl        (dctl),
    .idle_in     (idle_cycle_count),
    .total_in    (total_cycle_count),
    .weighted_in (weighted_load_count),
    .time_in     (sample_time),
    .d_busy      (d_busy),
    .d_total     (d_total),
    .d_weighted  (d_weighted),
    .d_time      (d_time),
    .time_nz     (time_nz)
  );

  ccl_gov_div u_div_util (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (d_busy),
    .den   (d_time),
    .busy  (busy_u),
    .quo   (util_q)
  );

  ccl_gov_div u_div_lf (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (d_weighted),
    .den   (d_total),
    .busy  (busy_l),
    .quo   (lf_q)
  );

  // core count and products
  logic [CW-1:0]   n_ext, c_clamp, c_r, c_m1;
  logic [HP_W-1:0] hyst_prod;
  logic [MP_W-1:0] mu_prod;

  always_comb begin
    n_ext = CW'(active_cores);
    if (n_ext == '0) begin
      c_clamp = CW'(1);
    end else if (n_ext > CW'(ccl_gov_pkg::MAX_CORES)) begin
      c_clamp = CW'(ccl_gov_pkg::MAX_CORES);
    end else begin
      c_clamp = n_ext;
    end
  end

  assign c_m1 = c_r - CW'(1);

  // ramp thresholds
  logic [ccl_gov_pkg::MAX_CORES-1:0] vbits;
  logic [QW-1:0]                     ram_rd, thr;
  logic                              ram_we, grow;

  ccl_gov_ram #(
    .WIDTH (QW),
    .DEPTH (ccl_gov_pkg::MAX_CORES)
  ) u_ramp (
    .clk   (clk),
    .we    (ram_we),
    .waddr (c_r[IW-1:0]),
    .wdata (util_q),
    .raddr (c_m1[IW-1:0]),
    .rdata (ram_rd)
  );

  // decision
  logic signed [SW-1:0] loc, loc_c, flr, util_s, hi, lo;
  ccl_gov_pkg::dec_t    dec_c;

  always_comb begin
    thr    = vbits[c_m1[IW-1:0]] ? ram_rd : '0;
    loc    = $signed(SW'(thr)) - $signed(SW'(hyst_prod));
    flr    = $signed(SW'(zero_core_floor));
    loc_c  = (loc < flr) ? flr : loc;
    util_s = $signed(SW'(util_q));
    hi     = $signed(SW'(mu_prod));
    lo     = $signed(SW'(mu_prod)) - $signed(SW'(max_utilization))
             - $signed(SW'(idle_hysteresis));
    grow   = (c_r < CW'(ccl_gov_pkg::MAX_CORES)) && (lf_q > load_factor_limit);
    dec_c  = ccl_gov_pkg::DEC_HOLD;
    if (strategy == ccl_gov_pkg::STRAT_LOAD) begin
      if (grow) begin
        dec_c = ccl_gov_pkg::DEC_INC;
      end else if (util_s < loc_c) begin
        dec_c = ccl_gov_pkg::DEC_DEC;
      end
    end else begin
      if (util_s > hi) begin
        dec_c = ccl_gov_pkg::DEC_INC;
      end else if (util_s < lo) begin
        dec_c = ccl_gov_pkg::DEC_DEC;
      end
    end
    ram_we = (state == ccl_gov_pkg::ST_DECIDE) && (strategy == ccl_gov_pkg::STRAT_LOAD)
             && grow;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      hist      <= 1'b0;
      dcnt      <= '0;
      vbits     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (acc && (kind == ccl_gov_pkg::KIND_CLEAR)) begin
        hist <= 1'b0;
      end
      if (state == ccl_gov_pkg::ST_SHIFT) begin
        if (dcnt == DCW'(ccl_gov_pkg::DIGITS - 1)) begin
          dcnt <= '0;
          hist <= time_nz;
        end else begin
          dcnt <= dcnt + DCW'(1);
        end
      end
      if (ram_we) begin
        vbits[c_r[IW-1:0]] <= 1'b1;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  ccl_gov_pkg::dec_t p_dec, o_dec;
  logic [QW-1:0]     p_util, p_lf;
  logic              p_first;

  always_ff @(posedge clk) begin
    hyst_prod <= HP_W'(idle_hysteresis) * HP_W'(c_m1);
    mu_prod   <= MP_W'(max_utilization) * MP_W'(c_r);
    if (acc) begin
      rec     <= !hist;
      c_r     <= c_clamp;
      p_dec   <= ccl_gov_pkg::DEC_HOLD;
      p_util  <= '0;
      p_lf    <= '0;
      p_first <= 1'b0;
    end
    if ((state == ccl_gov_pkg::ST_SHIFT) && rec) begin
      p_first <= 1'b1;
    end
    if (state == ccl_gov_pkg::ST_DECIDE) begin
      p_dec  <= dec_c;
      p_util <= util_q;
      p_lf   <= lf_q;
    end
    if (emit) begin
      o_dec          <= p_dec;
      utilized_cores <= p_util;
      load_ratio     <= p_lf;
      first_sample   <= p_first;
    end
  end

  assign decision = o_dec;

  // checks
  `CCLG_ASSERT_IMP(a_rise_from_emit, clk, rst, $rose(out_valid),
                   $past(state) == ccl_gov_pkg::ST_EMIT)
  `CCLG_ASSERT_IMP(a_first_zero, clk, rst, out_valid && first_sample,
                   (decision == ccl_gov_pkg::DEC_HOLD) && (utilized_cores == '0)
                   && (load_ratio == '0))
  `CCLG_ASSERT_IMP(a_div_done, clk, rst, state == ccl_gov_pkg::ST_DECIDE,
                   !busy_u && !busy_l)
  `CCLG_ASSERT_NXT(a_div_runs, clk, rst, state == ccl_gov_pkg::ST_DIVGO,
                   busy_u && busy_l)

endmodule

`default_nettype wire

/* src/ccl_gov_ram.sv */
// ----------------------------------------------------------------------------
// Core count load governor: generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ccl_gov_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* src/ccl_gov_delta.sv */
// ----------------------------------------------------------------------------
// Core count load governor: serial delta unit
// Holds the previous snapshot and forms the four counter deltas one digit
// per cycle, low digit first; the new snapshot rotates in as the old leaves.
// ----------------------------------------------------------------------------
`default_nettype none

module ccl_gov_delta (
  input  logic                              clk,
  input  ccl_gov_pkg::dlt_ctrl_t            ctrl,
  input  logic [ccl_gov_pkg::FIELD_W-1:0]   idle_in,
  input  logic [ccl_gov_pkg::FIELD_W-1:0]   total_in,
  input  logic [ccl_gov_pkg::FIELD_W-1:0]   weighted_in,
  input  logic [ccl_gov_pkg::FIELD_W-1:0]   time_in,
  output logic [ccl_gov_pkg::FIELD_W-1:0]   d_busy,
  output logic [ccl_gov_pkg::FIELD_W-1:0]   d_total,
  output logic [ccl_gov_pkg::FIELD_W-1:0]   d_weighted,
  output logic [ccl_gov_pkg::FIELD_W-1:0]   d_time,
  output logic                              time_nz
);

  localparam int FW = ccl_gov_pkg::FIELD_W;
  localparam int DW = ccl_gov_pkg::DIG_W;

  function automatic logic [DW:0] sub_dig(input logic [DW-1:0] a, input logic [DW-1:0] b,
                                          input logic bin);
    sub_dig = {1'b0, a} - {1'b0, b} - (DW+1)'(bin);
  endfunction

  logic [FW-1:0] s_idle, s_total, s_weighted, s_time;
  logic [FW-1:0] last_idle, last_total, last_weighted, last_time;
  logic          b_idle, b_total, b_weighted, b_time, b_busy;
  logic          tnz;

  logic [DW:0] r_idle, r_total, r_weighted, r_time, r_busy;

  always_comb begin
    r_idle     = sub_dig(s_idle[DW-1:0], last_idle[DW-1:0], b_idle);
    r_total    = sub_dig(s_total[DW-1:0], last_total[DW-1:0], b_total);
    r_weighted = sub_dig(s_weighted[DW-1:0], last_weighted[DW-1:0], b_weighted);
    r_time     = sub_dig(s_time[DW-1:0], last_time[DW-1:0], b_time);
    r_busy     = sub_dig(r_total[DW-1:0], r_idle[DW-1:0], b_busy);
  end

  assign time_nz = tnz | (|s_time[DW-1:0]);

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      s_idle     <= idle_in;
      s_total    <= total_in;
      s_weighted <= weighted_in;
      s_time     <= time_in;
      b_idle     <= 1'b0;
      b_total    <= 1'b0;
      b_weighted <= 1'b0;
      b_time     <= 1'b0;
      b_busy     <= 1'b0;
      tnz        <= 1'b0;
    end else if (ctrl.step) begin
      s_idle        <= s_idle >> DW;
      s_total       <= s_total >> DW;
      s_weighted    <= s_weighted >> DW;
      s_time        <= s_time >> DW;
      last_idle     <= {s_idle[DW-1:0], last_idle[FW-1:DW]};
      last_total    <= {s_total[DW-1:0], last_total[FW-1:DW]};
      last_weighted <= {s_weighted[DW-1:0], last_weighted[FW-1:DW]};
      last_time     <= {s_time[DW-1:0], last_time[FW-1:DW]};
      d_busy        <= {r_busy[DW-1:0], d_busy[FW-1:DW]};
      d_total       <= {r_total[DW-1:0], d_total[FW-1:DW]};
      d_weighted    <= {r_weighted[DW-1:0], d_weighted[FW-1:DW]};
      d_time        <= {r_time[DW-1:0], d_time[FW-1:DW]};
      b_idle        <= r_idle[DW];
      b_total       <= r_total[DW];
      b_weighted    <= r_weighted[DW];
      b_time        <= r_time[DW];
      b_busy        <= r_busy[DW];
      tnz           <= time_nz;
    end
  end

endmodule

`default_nettype wire

/* src/ccl_gov_div.sv */
// ----------------------------------------------------------------------------
// Core count load governor: Q8.16 divider
// Restoring division, one quotient bit per cycle; an overflow check cycle
// first saturates on a zero divisor or a quotient of 256.0 or more.
// ----------------------------------------------------------------------------
`default_nettype none

module ccl_gov_div (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [ccl_gov_pkg::FIELD_W-1:0]  num,
  input  logic [ccl_gov_pkg::FIELD_W-1:0]  den,
  output logic                             busy,
  output logic [ccl_gov_pkg::Q_W-1:0]      quo
);

  localparam int FW    = ccl_gov_pkg::FIELD_W;
  localparam int QW    = ccl_gov_pkg::Q_W;
  localparam int QIW   = ccl_gov_pkg::QI_W;
  localparam int STP_W = $clog2(QW);

  logic [FW-1:0]    r, den_r;
  logic [QIW-1:0]   low;
  logic [QW-1:0]    q;
  logic [STP_W-1:0] step;
  logic             chk, sat, run;

  logic [FW:0]   opd;
  logic [FW+1:0] diff;
  logic          ge;

  always_comb begin
    opd  = chk ? {1'b0, r} : {r, low[QIW-1]};
    diff = {1'b0, opd} - {2'b00, den_r};
    ge   = ~diff[FW+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
    end else if (start) begin
      run <= 1'b1;
    end else if (run && (chk ? ge : (step == STP_W'(QW - 1)))) begin
      run <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      r     <= FW'(num >> QIW);
      low   <= num[QIW-1:0];
      den_r <= den;
      q     <= '0;
      step  <= '0;
      chk   <= 1'b1;
      sat   <= 1'b0;
    end else if (run) begin
      if (chk) begin
        chk <= 1'b0;
        sat <= ge;
      end else begin
        r    <= ge ? diff[FW-1:0] : opd[FW-1:0];
        q    <= {q[QW-2:0], ge};
        low  <= low << 1;
        step <= step + STP_W'(1);
      end
    end
  end

  assign busy = run;
  assign quo  = sat ? {QW{1'b1}} : q;

endmodule

`default_nettype wire
